@@ sv/spmq_pkg.sv @@
`default_nettype none

package spmq_pkg;

  localparam int LEVELS_DEF      = 8;
  localparam int DEPTH_DEF       = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  // Widths fixed by the request and result formats.
  localparam int LEVEL_W     = 4;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int TOTAL_OUT_W = 8;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADDR = 4'b0010,
    S_DATA = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

`default_nettype wire

@@ sv/spmq_ram.sv @@
`default_nettype none

module spmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                   wdata,
  input  wire logic                               re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/strict_priority_multi_queue.sv @@
`default_nettype none

// Strict-priority queue with one FIFO of DEPTH_PER_LEVEL entries per level; level 0
// is served first. A push (opcode 0) appends value to its level, a pop (opcode 1)
// takes the oldest entry of the most urgent non-empty level. Every request gives one
// result with status, popped value, total entry count and the new head of the queue.
// Failed requests (pop on empty, push to a full level, level out of range) leave the
// state unchanged. Entries live in one simple dual-port RAM; the current head is kept
// in a register. One request is handled at a time. A push or a failed request goes
// straight from S_IDLE to S_DONE. A successful pop must read the new head back from
// the entry RAM after the pointer update: S_ADDR issues the read and S_DATA loads the
// RAM output into the head register before S_DONE. A pop that empties the queue needs
// no read and goes from S_ADDR to S_DONE. A result waiting on out_stall holds back the
// next one.
module strict_priority_multi_queue
  import spmq_pkg::*;
#(
  parameter int LEVELS          = LEVELS_DEF,
  parameter int DEPTH_PER_LEVEL = DEPTH_DEF,
  parameter int DATA_WIDTH      = DATA_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       opcode,
  input  wire logic [LEVEL_W-1:0]         level,
  input  wire logic signed [VALUE_W-1:0]  value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [STATUS_W-1:0]             status,
  output logic signed [VALUE_W-1:0]       popped_value,
  output logic [TOTAL_OUT_W-1:0]          total_count,
  output logic                            head_valid,
  output logic signed [VALUE_W-1:0]       head_value
);

  localparam int LVL_IDX_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int FIRST_W     = $clog2(LEVELS + 1);
  localparam int PTR_W       = $clog2(DEPTH_PER_LEVEL);
  localparam int CNT_W       = $clog2(DEPTH_PER_LEVEL + 1);
  localparam int STORE_DEPTH = LEVELS * DEPTH_PER_LEVEL;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int TOTAL_W     = $clog2(STORE_DEPTH + 1);
  localparam int LVL_CMP_W   = LEVEL_W + 1;

  state_t                 state;
  logic [CNT_W-1:0]       count [LEVELS];
  logic [PTR_W-1:0]       head [LEVELS];
  logic [PTR_W-1:0]       tail [LEVELS];
  logic [TOTAL_W-1:0]     total;
  logic [DATA_WIDTH-1:0]  cache;
  logic [DATA_WIDTH-1:0]  popped_q;
  status_t                status_q;

  logic [FIRST_W-1:0]     first_lvl;
  logic                   empty_all;
  logic [LVL_IDX_W-1:0]   head_idx;
  logic [LVL_IDX_W-1:0]   push_idx;
  logic [PTR_W-1:0]       head_ptr;
  logic [PTR_W-1:0]       head_adv;
  logic [PTR_W-1:0]       tail_ptr;
  logic [PTR_W-1:0]       tail_adv;
  logic                   accept;
  logic                   is_pop;
  logic                   in_range;
  logic                   push_full;
  logic                   push_ok;
  logic                   pop_ok;
  status_t                req_status;
  logic                   ram_we;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0]  ram_wdata;
  logic [DATA_WIDTH-1:0]  ram_rdata;
  logic                   out_free;

  // Most urgent non-empty level, or LEVELS when every level is empty.
  always_comb begin
    first_lvl = FIRST_W'(LEVELS);
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        first_lvl = FIRST_W'(i);
      end
    end
  end

  assign empty_all = (first_lvl == FIRST_W'(LEVELS));
  assign head_idx  = first_lvl[LVL_IDX_W-1:0];
  assign push_idx  = level[LVL_IDX_W-1:0];

  assign head_ptr = head[head_idx];
  assign tail_ptr = tail[push_idx];
  assign head_adv = (head_ptr == PTR_W'(DEPTH_PER_LEVEL - 1)) ? '0 : head_ptr + 1'b1;
  assign tail_adv = (tail_ptr == PTR_W'(DEPTH_PER_LEVEL - 1)) ? '0 : tail_ptr + 1'b1;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_pop    = (opcode == OP_POP);
  assign in_range  = ({1'b0, level} < LVL_CMP_W'(LEVELS));
  assign push_full = (count[push_idx] == CNT_W'(DEPTH_PER_LEVEL));
  assign push_ok   = accept && !is_pop && in_range && !push_full;
  assign pop_ok    = accept && is_pop && !empty_all;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (is_pop) begin
      req_status = empty_all ? ST_EMPTY : ST_OK;
    end else if (!in_range) begin
      req_status = ST_RANGE;
    end else if (push_full) begin
      req_status = ST_FULL;
    end else begin
      req_status = ST_OK;
    end
  end

  assign ram_we    = push_ok;
  assign ram_waddr = ADDR_W'(push_idx) * ADDR_W'(DEPTH_PER_LEVEL) + ADDR_W'(tail_ptr);
  assign ram_wdata = DATA_WIDTH'($unsigned(value));
  // After a pop the counters are already updated, so the head index names the new head.
  assign ram_re    = (state == S_ADDR) && (total != '0);
  assign ram_raddr = ADDR_W'(head_idx) * ADDR_W'(DEPTH_PER_LEVEL) + ADDR_W'(head_ptr);

  spmq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      total     <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        count[i] <= '0;
        head[i]  <= '0;
        tail[i]  <= '0;
      end
    end else begin
      // In S_DONE a leaving result is replaced by the new one below.
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            status_q <= req_status;
            popped_q <= pop_ok ? cache : '0;
            state    <= pop_ok ? S_ADDR : S_DONE;
            if (push_ok) begin
              tail[push_idx]  <= tail_adv;
              count[push_idx] <= count[push_idx] + 1'b1;
              total           <= total + 1'b1;
              // A push to a more urgent level than the current head, or into an
              // empty queue, becomes the new head.
              if (FIRST_W'(push_idx) < first_lvl) begin
                cache <= ram_wdata;
              end
            end
            if (pop_ok) begin
              head[head_idx]  <= head_adv;
              count[head_idx] <= count[head_idx] - 1'b1;
              total           <= total - 1'b1;
            end
          end
        end
        S_ADDR: begin
          state <= (total != '0) ? S_DATA : S_DONE;
        end
        S_DATA: begin
          cache <= ram_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= status_q;
            popped_value <= $signed(VALUE_W'(popped_q));
            total_count  <= TOTAL_OUT_W'(total);
            head_valid   <= (total != '0);
            head_value   <= (total != '0) ? $signed(VALUE_W'(cache)) : '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_pop_decrements_total: assert property (@(posedge clk) disable iff (rst)
    pop_ok |=> (total == $past(total) - 1'b1))
    else $error("successful pop did not decrement the total count");

  a_read_only_when_nonempty: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> !empty_all)
    else $error("entry read issued while every level is empty");

  a_empty_pop_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_EMPTY)) |-> (!head_valid && (popped_value == '0)))
    else $error("pop on empty reported a value or a head");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TOTAL_W'(STORE_DEPTH))
    else $error("total count exceeds the store capacity");
`endif

endmodule

`default_nettype wire
